// File: rtl/core/mcwg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the motion command watchdog gate.
// Holds event codes, result causes, register indexes and reset values; no dependencies.
package mcwg_pkg;

    localparam int VEL_W   = 16;
    localparam int LIMIT_W = 15;
    localparam int TICKS_W = 16;
    localparam int AGE_W   = 17;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 16;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    typedef enum logic [2:0] {
        OP_VELOCITY = 3'd0,
        OP_ENABLE   = 3'd1,
        OP_STATE    = 3'd2,
        OP_TIME     = 3'd3,
        OP_TICK     = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        CAUSE_NORMAL         = 3'd0,
        CAUSE_STATE_STALE    = 3'd1,
        CAUSE_CMD_TIMEOUT    = 3'd2,
        CAUSE_INVALID_CMD    = 3'd3,
        CAUSE_ENABLE_CHANGE  = 3'd4,
        CAUSE_ENABLE_REFUSED = 3'd5
    } cause_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_LIMIT_FORWARD  = 3'd0,
        REG_LIMIT_SIDEWAYS = 3'd1,
        REG_LIMIT_TURN     = 3'd2,
        REG_CMD_TIMEOUT    = 3'd3,
        REG_STATE_TIMEOUT  = 3'd4,
        REG_REQUIRE_STATE  = 3'd5,
        REG_START_ENABLED  = 3'd6
    } reg_index_t;

    localparam logic [LIMIT_W-1:0] LIMIT_FORWARD_RST  = 15'd205;
    localparam logic [LIMIT_W-1:0] LIMIT_SIDEWAYS_RST = 15'd0;
    localparam logic [LIMIT_W-1:0] LIMIT_TURN_RST     = 15'd614;
    localparam logic [TICKS_W-1:0] CMD_TIMEOUT_RST    = 16'd250;
    localparam logic [TICKS_W-1:0] STATE_TIMEOUT_RST  = 16'd500;
    localparam logic               REQUIRE_STATE_RST  = 1'b1;
    localparam logic               START_ENABLED_RST  = 1'b0;

endpackage

// File: rtl/core/motion_command_watchdog_gate_core.sv
`timescale 1ns / 1ps
// Top level of the motion command watchdog gate: event decoding, gate state and result register.
// Depends on mcwg_pkg and mcwg_clamp.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | op, three velocities, values_valid, enable_wanted
//  m_      | out       | m_valid / m_ready  | send flag, three velocities, reply flags, flags, cause
//  cfg_    | in        | cfg_wr_en          | cfg_addr, cfg_wdata
//
// Every transaction is decided in the cycle it is accepted; its result, if any, appears in the
// result register on the next cycle; with m_ready high, one transaction per cycle is sustained.
// The result register is the only stage: s_ready is high while it is empty or being drained.
// Reset is synchronous and active low; it restores all but the result data registers at once.
module motion_command_watchdog_gate_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [2:0]                           s_op,
    input  logic signed [mcwg_pkg::VEL_W-1:0]    s_vel_forward,
    input  logic signed [mcwg_pkg::VEL_W-1:0]    s_vel_sideways,
    input  logic signed [mcwg_pkg::VEL_W-1:0]    s_vel_turn,
    input  logic                                 s_values_valid,
    input  logic                                 s_enable_wanted,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_send_velocity,
    output logic signed [mcwg_pkg::VEL_W-1:0]    m_out_forward,
    output logic signed [mcwg_pkg::VEL_W-1:0]    m_out_sideways,
    output logic signed [mcwg_pkg::VEL_W-1:0]    m_out_turn,
    output logic                                 m_is_reply,
    output logic                                 m_reply_ok,
    output logic                                 m_enabled_now,
    output logic                                 m_stopped_now,
    output logic [2:0]                           m_cause,

    input  logic                                 cfg_wr_en,
    input  logic [mcwg_pkg::CFG_AW-1:0]          cfg_addr,
    input  logic [mcwg_pkg::CFG_DW-1:0]          cfg_wdata
);
    import mcwg_pkg::*;

    logic [LIMIT_W-1:0] limit_forward_reg, limit_sideways_reg, limit_turn_reg;
    logic [TICKS_W-1:0] cmd_timeout_reg, state_timeout_reg;
    logic               require_state_reg;

    logic                    control_on_reg, control_on_next;
    logic                    have_state_reg, have_state_next;
    logic                    stop_latched_reg, stop_latched_next;
    logic signed [VEL_W-1:0] want_forward_reg, want_forward_next;
    logic signed [VEL_W-1:0] want_sideways_reg, want_sideways_next;
    logic signed [VEL_W-1:0] want_turn_reg, want_turn_next;
    logic [AGE_W-1:0]        command_age_reg, command_age_next;
    logic [AGE_W-1:0]        state_age_reg, state_age_next;

    logic                    m_valid_reg;
    logic                    m_send_reg, m_send_next;
    logic signed [VEL_W-1:0] m_forward_reg, m_forward_next;
    logic signed [VEL_W-1:0] m_sideways_reg, m_sideways_next;
    logic signed [VEL_W-1:0] m_turn_reg, m_turn_next;
    logic                    m_reply_reg, m_reply_next;
    logic                    m_ok_reg, m_ok_next;
    logic                    m_enabled_reg;
    logic                    m_stopped_reg;
    cause_t                  m_cause_reg, m_cause_next;
    logic                    res_valid;

    logic                    s_accept;
    logic                    state_recent;
    logic                    state_stale;
    logic                    cmd_expired;
    logic signed [VEL_W-1:0] clamp_forward, clamp_sideways, clamp_turn;

    mcwg_clamp u_clamp_forward (
        .vel(s_vel_forward), .limit(limit_forward_reg), .clamped(clamp_forward)
    );
    mcwg_clamp u_clamp_sideways (
        .vel(s_vel_sideways), .limit(limit_sideways_reg), .clamped(clamp_sideways)
    );
    mcwg_clamp u_clamp_turn (
        .vel(s_vel_turn), .limit(limit_turn_reg), .clamped(clamp_turn)
    );

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign state_recent = have_state_reg && (state_age_reg <= {1'b0, state_timeout_reg});
    assign state_stale  = require_state_reg && !state_recent;
    assign cmd_expired  = command_age_reg > {1'b0, cmd_timeout_reg};

    // The start value of the enable flag is the constant START_ENABLED_RST, used only at reset,
    // so a write to its register index is accepted and has no effect.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_forward_reg  <= LIMIT_FORWARD_RST;
            limit_sideways_reg <= LIMIT_SIDEWAYS_RST;
            limit_turn_reg     <= LIMIT_TURN_RST;
            cmd_timeout_reg    <= CMD_TIMEOUT_RST;
            state_timeout_reg  <= STATE_TIMEOUT_RST;
            require_state_reg  <= REQUIRE_STATE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_LIMIT_FORWARD:  limit_forward_reg  <= cfg_wdata[LIMIT_W-1:0];
                REG_LIMIT_SIDEWAYS: limit_sideways_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_LIMIT_TURN:     limit_turn_reg     <= cfg_wdata[LIMIT_W-1:0];
                REG_CMD_TIMEOUT:    cmd_timeout_reg    <= cfg_wdata[TICKS_W-1:0];
                REG_STATE_TIMEOUT:  state_timeout_reg  <= cfg_wdata[TICKS_W-1:0];
                REG_REQUIRE_STATE:  require_state_reg  <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        control_on_next    = control_on_reg;
        have_state_next    = have_state_reg;
        stop_latched_next  = stop_latched_reg;
        want_forward_next  = want_forward_reg;
        want_sideways_next = want_sideways_reg;
        want_turn_next     = want_turn_reg;
        command_age_next   = command_age_reg;
        state_age_next     = state_age_reg;

        res_valid       = 1'b0;
        m_send_next     = 1'b1;
        m_forward_next  = '0;
        m_sideways_next = '0;
        m_turn_next     = '0;
        m_reply_next    = 1'b0;
        m_ok_next       = 1'b0;
        m_cause_next    = CAUSE_NORMAL;

        case (s_op)
            OP_VELOCITY: begin
                if (!s_values_valid) begin
                    want_forward_next  = '0;
                    want_sideways_next = '0;
                    want_turn_next     = '0;
                    command_age_next   = AGE_MAX;
                    stop_latched_next  = 1'b1;
                    res_valid          = control_on_reg;
                    m_cause_next       = CAUSE_INVALID_CMD;
                end else begin
                    want_forward_next  = clamp_forward;
                    want_sideways_next = clamp_sideways;
                    want_turn_next     = clamp_turn;
                    command_age_next   = '0;
                    stop_latched_next  = 1'b0;
                end
            end
            OP_ENABLE: begin
                res_valid    = 1'b1;
                m_reply_next = 1'b1;
                if (s_enable_wanted && state_stale) begin
                    m_send_next  = 1'b0;
                    m_cause_next = CAUSE_ENABLE_REFUSED;
                end else begin
                    control_on_next    = s_enable_wanted;
                    want_forward_next  = '0;
                    want_sideways_next = '0;
                    want_turn_next     = '0;
                    command_age_next   = AGE_MAX;
                    stop_latched_next  = 1'b0;
                    m_ok_next          = 1'b1;
                    m_cause_next       = CAUSE_ENABLE_CHANGE;
                end
            end
            OP_STATE: begin
                have_state_next = 1'b1;
                state_age_next  = '0;
            end
            OP_TIME: begin
                if (command_age_reg != AGE_MAX) begin
                    command_age_next = command_age_reg + 1'b1;
                end
                if (state_age_reg != AGE_MAX) begin
                    state_age_next = state_age_reg + 1'b1;
                end
            end
            OP_TICK: begin
                if (control_on_reg) begin
                    if (state_stale) begin
                        res_valid         = !stop_latched_reg;
                        stop_latched_next = 1'b1;
                        m_cause_next      = CAUSE_STATE_STALE;
                    end else if (cmd_expired) begin
                        res_valid         = !stop_latched_reg;
                        stop_latched_next = 1'b1;
                        m_cause_next      = CAUSE_CMD_TIMEOUT;
                    end else begin
                        res_valid       = 1'b1;
                        m_forward_next  = want_forward_reg;
                        m_sideways_next = want_sideways_reg;
                        m_turn_next     = want_turn_reg;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_on_reg    <= START_ENABLED_RST;
            have_state_reg    <= 1'b0;
            stop_latched_reg  <= 1'b0;
            want_forward_reg  <= '0;
            want_sideways_reg <= '0;
            want_turn_reg     <= '0;
            command_age_reg   <= AGE_MAX;
            state_age_reg     <= '0;
        end else if (s_accept) begin
            control_on_reg    <= control_on_next;
            have_state_reg    <= have_state_next;
            stop_latched_reg  <= stop_latched_next;
            want_forward_reg  <= want_forward_next;
            want_sideways_reg <= want_sideways_next;
            want_turn_reg     <= want_turn_next;
            command_age_reg   <= command_age_next;
            state_age_reg     <= state_age_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= res_valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            m_send_reg     <= m_send_next;
            m_forward_reg  <= m_forward_next;
            m_sideways_reg <= m_sideways_next;
            m_turn_reg     <= m_turn_next;
            m_reply_reg    <= m_reply_next;
            m_ok_reg       <= m_ok_next;
            m_enabled_reg  <= control_on_next;
            m_stopped_reg  <= stop_latched_next;
            m_cause_reg    <= m_cause_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_send_velocity = m_send_reg;
    assign m_out_forward   = m_forward_reg;
    assign m_out_sideways  = m_sideways_reg;
    assign m_out_turn      = m_turn_reg;
    assign m_is_reply      = m_reply_reg;
    assign m_reply_ok      = m_ok_reg;
    assign m_enabled_now   = m_enabled_reg;
    assign m_stopped_now   = m_stopped_reg;
    assign m_cause         = m_cause_reg;

    a_refused_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cause == CAUSE_ENABLE_REFUSED |-> m_is_reply && !m_reply_ok && !m_send_velocity)
        else $error("refused enable result has wrong flags");

    a_stop_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cause != CAUSE_NORMAL
        |-> m_out_forward == '0 && m_out_sideways == '0 && m_out_turn == '0)
        else $error("stop or reply result carries a nonzero velocity");

    a_state_arrival: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_op == OP_STATE |=> have_state_reg && state_age_reg == '0)
        else $error("state arrival did not refresh the state age");

    a_stale_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_op == OP_TICK && control_on_reg && state_stale && !stop_latched_reg
        |=> m_valid && m_cause == CAUSE_STATE_STALE && m_stopped_now)
        else $error("stale state did not produce a latched stop");

endmodule

// File: rtl/core/mcwg_clamp.sv
`timescale 1ns / 1ps
// Symmetric clamp of one signed Q3.12 velocity to [-limit, +limit].
// Depends on mcwg_pkg for the velocity and limit widths.
module mcwg_clamp (
    input  logic signed [mcwg_pkg::VEL_W-1:0]   vel,
    input  logic        [mcwg_pkg::LIMIT_W-1:0] limit,
    output logic signed [mcwg_pkg::VEL_W-1:0]   clamped
);
    import mcwg_pkg::*;

    logic signed [VEL_W-1:0] pos_lim;
    logic signed [VEL_W-1:0] neg_lim;

    assign pos_lim = $signed({1'b0, limit});
    assign neg_lim = -pos_lim;

    always_comb begin
        if (vel > pos_lim) begin
            clamped = pos_lim;
        end else if (vel < neg_lim) begin
            clamped = neg_lim;
        end else begin
            clamped = vel;
        end
    end

endmodule

// File: verif/mcwg_checker.sv
`timescale 1ns / 1ps
// Result checker for the motion command watchdog gate: follows every accepted transaction,
// predicts the result it causes and compares each delivered result field by field.
// Depends on mcwg_pkg; tb_top instantiates it beside the block.
module mcwg_checker (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [2:0]                    s_op,
    input  logic [mcwg_pkg::VEL_W-1:0]    s_vel_forward,
    input  logic [mcwg_pkg::VEL_W-1:0]    s_vel_sideways,
    input  logic [mcwg_pkg::VEL_W-1:0]    s_vel_turn,
    input  logic                          s_values_valid,
    input  logic                          s_enable_wanted,

    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_send_velocity,
    input  logic [mcwg_pkg::VEL_W-1:0]    m_out_forward,
    input  logic [mcwg_pkg::VEL_W-1:0]    m_out_sideways,
    input  logic [mcwg_pkg::VEL_W-1:0]    m_out_turn,
    input  logic                          m_is_reply,
    input  logic                          m_reply_ok,
    input  logic                          m_enabled_now,
    input  logic                          m_stopped_now,
    input  logic [2:0]                    m_cause,

    input  logic                          cfg_wr_en,
    input  logic [mcwg_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [mcwg_pkg::CFG_DW-1:0]   cfg_wdata,

    output int                            fail_count,
    output int                            outstanding
);
    import mcwg_pkg::*;

    localparam int SHOWN_MAX = 100;

    typedef struct packed {
        logic             send_velocity;
        logic [VEL_W-1:0] out_forward;
        logic [VEL_W-1:0] out_sideways;
        logic [VEL_W-1:0] out_turn;
        logic             is_reply;
        logic             reply_ok;
        logic             enabled_now;
        logic             stopped_now;
        logic [2:0]       cause;
    } gate_answer_t;

    gate_answer_t gate_answers[$];
    int           mismatches = 0;

    logic [LIMIT_W-1:0] limit_fwd, limit_side, limit_yaw;
    logic [TICKS_W-1:0] cmd_timeout, state_timeout;
    logic               require_state, start_enabled;

    logic               control_on, have_state, stop_latched;
    logic [VEL_W-1:0]   want_fwd, want_side, want_yaw;
    logic [AGE_W-1:0]   cmd_age, state_age;

    function automatic logic [VEL_W-1:0] clamp_sym(input logic [VEL_W-1:0] v,
                                                   input logic [LIMIT_W-1:0] lim);
        int value;
        int bound;
        value = $signed(v);
        bound = lim;
        if (value > bound) begin
            value = bound;
        end else if (value < -bound) begin
            value = -bound;
        end
        return value[VEL_W-1:0];
    endfunction

    function automatic logic [AGE_W-1:0] age_step(input logic [AGE_W-1:0] age);
        return (age == AGE_MAX) ? AGE_MAX : age + 1'b1;
    endfunction

    function automatic logic state_recent();
        return have_state && (state_age <= {1'b0, state_timeout});
    endfunction

    task automatic drop_wanted();
        want_fwd  = '0;
        want_side = '0;
        want_yaw  = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [VEL_W-1:0] got,
                                   input logic [VEL_W-1:0] want);
        mismatches++;
        if (mismatches <= SHOWN_MAX)
            $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [VEL_W-1:0] got,
                               input logic [VEL_W-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic write_register(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        case (addr)
            REG_LIMIT_FORWARD:  limit_fwd     = data[LIMIT_W-1:0];
            REG_LIMIT_SIDEWAYS: limit_side    = data[LIMIT_W-1:0];
            REG_LIMIT_TURN:     limit_yaw     = data[LIMIT_W-1:0];
            REG_CMD_TIMEOUT:    cmd_timeout   = data[TICKS_W-1:0];
            REG_STATE_TIMEOUT:  state_timeout = data[TICKS_W-1:0];
            REG_REQUIRE_STATE:  require_state = data[0];
            REG_START_ENABLED:  start_enabled = data[0];
            default: ;
        endcase
    endtask

    // Appends one expected result at the tail of the queue.
    task automatic queue_answer(input gate_answer_t ans);
        gate_answers.insert(gate_answers.size(), ans);
    endtask

    // Updates the gate state for one event and queues the result it causes, if any.
    task automatic decide_event();
        gate_answer_t ans;
        logic         answered;
        ans      = '0;
        answered = 1'b0;
        case (s_op)
            OP_VELOCITY: begin
                if (!s_values_valid) begin
                    drop_wanted();
                    cmd_age      = AGE_MAX;
                    stop_latched = 1'b1;
                    if (control_on) begin
                        answered          = 1'b1;
                        ans.send_velocity = 1'b1;
                        ans.cause         = CAUSE_INVALID_CMD;
                    end
                end else begin
                    want_fwd     = clamp_sym(s_vel_forward, limit_fwd);
                    want_side    = clamp_sym(s_vel_sideways, limit_side);
                    want_yaw     = clamp_sym(s_vel_turn, limit_yaw);
                    cmd_age      = '0;
                    stop_latched = 1'b0;
                end
            end
            OP_ENABLE: begin
                answered     = 1'b1;
                ans.is_reply = 1'b1;
                if (s_enable_wanted && require_state && !state_recent()) begin
                    ans.cause = CAUSE_ENABLE_REFUSED;
                end else begin
                    control_on = s_enable_wanted;
                    drop_wanted();
                    cmd_age           = AGE_MAX;
                    stop_latched      = 1'b0;
                    ans.send_velocity = 1'b1;
                    ans.reply_ok      = 1'b1;
                    ans.cause         = CAUSE_ENABLE_CHANGE;
                end
            end
            OP_STATE: begin
                have_state = 1'b1;
                state_age  = '0;
            end
            OP_TIME: begin
                cmd_age   = age_step(cmd_age);
                state_age = age_step(state_age);
            end
            OP_TICK: begin
                if (control_on) begin
                    if (require_state && !state_recent()) begin
                        if (!stop_latched) begin
                            stop_latched      = 1'b1;
                            answered          = 1'b1;
                            ans.send_velocity = 1'b1;
                            ans.cause         = CAUSE_STATE_STALE;
                        end
                    end else if (cmd_age > {1'b0, cmd_timeout}) begin
                        if (!stop_latched) begin
                            stop_latched      = 1'b1;
                            answered          = 1'b1;
                            ans.send_velocity = 1'b1;
                            ans.cause         = CAUSE_CMD_TIMEOUT;
                        end
                    end else begin
                        answered          = 1'b1;
                        ans.send_velocity = 1'b1;
                        ans.out_forward   = want_fwd;
                        ans.out_sideways  = want_side;
                        ans.out_turn      = want_yaw;
                        ans.cause         = CAUSE_NORMAL;
                    end
                end
            end
            default: ;
        endcase
        ans.enabled_now = control_on;
        ans.stopped_now = stop_latched;
        if (answered)
            queue_answer(ans);
    endtask

    task automatic compare_answer();
        gate_answer_t want;
        if (gate_answers.size() == 0) begin
            report_mismatch("unexpected result, cause", m_cause, '0);
            return;
        end
        want = gate_answers.pop_front();
        check_field("send_velocity", m_send_velocity, want.send_velocity);
        check_field("out_forward", m_out_forward, want.out_forward);
        check_field("out_sideways", m_out_sideways, want.out_sideways);
        check_field("out_turn", m_out_turn, want.out_turn);
        check_field("is_reply", m_is_reply, want.is_reply);
        check_field("reply_ok", m_reply_ok, want.reply_ok);
        check_field("enabled_now", m_enabled_now, want.enabled_now);
        check_field("stopped_now", m_stopped_now, want.stopped_now);
        check_field("cause", m_cause, want.cause);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            limit_fwd     = LIMIT_FORWARD_RST;
            limit_side    = LIMIT_SIDEWAYS_RST;
            limit_yaw     = LIMIT_TURN_RST;
            cmd_timeout   = CMD_TIMEOUT_RST;
            state_timeout = STATE_TIMEOUT_RST;
            require_state = REQUIRE_STATE_RST;
            start_enabled = START_ENABLED_RST;
            control_on    = START_ENABLED_RST;
            have_state    = 1'b0;
            stop_latched  = 1'b0;
            drop_wanted();
            cmd_age       = AGE_MAX;
            state_age     = '0;
            gate_answers.delete();
        end else begin
            if (m_valid && m_ready)
                compare_answer();
            if (cfg_wr_en)
                write_register(cfg_addr, cfg_wdata);
            if (s_valid && s_ready)
                decide_event();
        end
        fail_count  <= mismatches;
        outstanding <= gate_answers.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the motion command watchdog gate testbench: clock, reset, configuration, event
// stimulus and result back-pressure, with the verdict taken from mcwg_checker.
// Depends on mcwg_pkg, motion_command_watchdog_gate_core and mcwg_checker.
module tb_top;
    import mcwg_pkg::*;

    localparam logic [2:0] OP_UNKNOWN_LO   = 3'd5;
    localparam logic [2:0] OP_UNKNOWN_HI   = 3'd7;
    localparam int         PHASE_EVENTS    = 170;
    localparam int         CLOSING_EVENTS  = 150;
    localparam int         HOLD_CYCLES     = 64;

    logic                    aclk;
    logic                    aresetn;

    logic                    s_valid;
    logic                    s_ready;
    logic [2:0]              s_op;
    logic signed [VEL_W-1:0] s_vel_forward;
    logic signed [VEL_W-1:0] s_vel_sideways;
    logic signed [VEL_W-1:0] s_vel_turn;
    logic                    s_values_valid;
    logic                    s_enable_wanted;

    logic                    m_valid;
    logic                    m_ready;
    logic                    m_send_velocity;
    logic signed [VEL_W-1:0] m_out_forward;
    logic signed [VEL_W-1:0] m_out_sideways;
    logic signed [VEL_W-1:0] m_out_turn;
    logic                    m_is_reply;
    logic                    m_reply_ok;
    logic                    m_enabled_now;
    logic                    m_stopped_now;
    logic [2:0]              m_cause;

    logic                    cfg_wr_en;
    logic [CFG_AW-1:0]       cfg_addr;
    logic [CFG_DW-1:0]       cfg_wdata;

    int                      fail_count;
    int                      outstanding;

    bit                      sender_quiet;
    bit                      sink_quiet;
    bit                      sink_hold_req;
    logic [LIMIT_W-1:0]      cur_limit_fwd, cur_limit_side, cur_limit_yaw;

    motion_command_watchdog_gate_core dut (.*);

    mcwg_checker gate_checker (.*);

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    initial begin
        #2_000_000;
        $display("motion_command_watchdog_gate_core test failed");
        $finish;
    end

    // Presents one event and returns at the edge where the transaction is accepted.
    task automatic put_event(input logic [2:0] op, input logic [VEL_W-1:0] fwd,
                             input logic [VEL_W-1:0] side, input logic [VEL_W-1:0] yaw,
                             input logic values_ok, input logic enable_on);
        if (!sender_quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_vel_forward   <= fwd;
        s_vel_sideways  <= side;
        s_vel_turn      <= yaw;
        s_values_valid  <= values_ok;
        s_enable_wanted <= enable_on;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops offering events and waits until every expected result has been delivered.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_config(input logic [CFG_DW-1:0] lim_fwd, input logic [CFG_DW-1:0] lim_side,
                                input logic [CFG_DW-1:0] lim_yaw, input logic [CFG_DW-1:0] cmd_ticks,
                                input logic [CFG_DW-1:0] state_ticks,
                                input logic [CFG_DW-1:0] need_state,
                                input logic [CFG_DW-1:0] start_on);
        reg_index_t        slot  [7];
        logic [CFG_DW-1:0] value [7];
        slot  = '{REG_LIMIT_FORWARD, REG_LIMIT_SIDEWAYS, REG_LIMIT_TURN, REG_CMD_TIMEOUT,
                  REG_STATE_TIMEOUT, REG_REQUIRE_STATE, REG_START_ENABLED};
        value = '{lim_fwd, lim_side, lim_yaw, cmd_ticks, state_ticks, need_state, start_on};
        for (int i = 0; i < 7; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= slot[i];
            cfg_wdata <= value[i];
            @(posedge aclk);
        end
        cfg_wr_en      <= 1'b0;
        cur_limit_fwd  = lim_fwd[LIMIT_W-1:0];
        cur_limit_side = lim_side[LIMIT_W-1:0];
        cur_limit_yaw  = lim_yaw[LIMIT_W-1:0];
    endtask

    function automatic logic [VEL_W-1:0] random_velocity(input logic [LIMIT_W-1:0] lim);
        int v;
        case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 65535);
            1: v = int'(lim) + $urandom_range(0, 4) - 2;
            2: v = -int'(lim) + $urandom_range(0, 4) - 2;
            3: v = $urandom_range(0, 1) ? 32767 : -32768;
            default: v = $urandom_range(0, 2 * lim + 16) - int'(lim) - 8;
        endcase
        return v[VEL_W-1:0];
    endfunction

    task automatic run_random(input int count, input bit allow_idle);
        logic [2:0] op;
        int         pick;
        for (int n = 0; n < count; n++) begin
            if (!allow_idle)
                sender_quiet = 1'b1;
            else if (n % 40 == 0)
                sender_quiet = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 20)
                op = OP_VELOCITY;
            else if (pick < 28)
                op = OP_ENABLE;
            else if (pick < 40)
                op = OP_STATE;
            else if (pick < 68)
                op = OP_TIME;
            else if (pick < 97)
                op = OP_TICK;
            else
                op = 3'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
            put_event(op, random_velocity(cur_limit_fwd), random_velocity(cur_limit_side),
                      random_velocity(cur_limit_yaw), $urandom_range(0, 99) < 85,
                      $urandom_range(0, 99) < 75);
        end
    endtask

    initial begin : result_sink
        int hold_cycles;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (sink_hold_req) begin
                m_ready     <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < HOLD_CYCLES) begin
                    @(posedge aclk);
                    hold_cycles++;
                end
                sink_hold_req = 1'b0;
            end else if (!sink_quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat (sink_quiet ? 1 : $urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        logic [LIMIT_W-1:0] lim [3];
        logic [TICKS_W-1:0] cmd_ticks, state_ticks;
        logic               need_state;

        s_valid         <= 1'b0;
        s_op            <= OP_TIME;
        s_vel_forward   <= '0;
        s_vel_sideways  <= '0;
        s_vel_turn      <= '0;
        s_values_valid  <= 1'b0;
        s_enable_wanted <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_addr        <= REG_LIMIT_FORWARD;
        cfg_wdata       <= '0;
        aresetn         <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short timeouts so that both stop reasons show up within a few events.
        apply_config(16'd205, 16'd0, 16'd614, 16'd4, 16'd3, 16'd1, 16'd1);
        put_event(OP_TICK, '0, '0, '0, 1'b1, 1'b0);
        put_event(OP_ENABLE, '0, '0, '0, 1'b1, 1'b1);
        put_event(OP_VELOCITY, 16'h1234, 16'h8000, 16'h7FFF, 1'b0, 1'b0);
        put_event(OP_STATE, '0, '0, '0, 1'b1, 1'b0);
        put_event(OP_ENABLE, '0, '0, '0, 1'b1, 1'b1);
        put_event(OP_TICK, '0, '0, '0, 1'b1, 1'b0);
        put_event(OP_TICK, '0, '0, '0, 1'b1, 1'b0);
        put_event(OP_VELOCITY, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1, 1'b0);
        put_event(OP_TICK, '0, '0, '0, 1'b1, 1'b0);
        put_event(OP_VELOCITY, 16'h8000, 16'h7FFF, 16'h8000, 1'b1, 1'b0);
        put_event(OP_TICK, '0, '0, '0, 1'b1, 1'b0);
        put_event(OP_VELOCITY, 16'd100, 16'hFFFF, 16'hFF9C, 1'b1, 1'b0);
        repeat (4) put_event(OP_TIME, '0, '0, '0, 1'b1, 1'b0);
        put_event(OP_TICK, '0, '0, '0, 1'b1, 1'b0);
        put_event(OP_TICK, '0, '0, '0, 1'b1, 1'b0);
        put_event(OP_STATE, '0, '0, '0, 1'b1, 1'b0);
        put_event(OP_TICK, '0, '0, '0, 1'b1, 1'b0);
        put_event(OP_VELOCITY, '0, '0, '0, 1'b0, 1'b1);
        put_event(OP_UNKNOWN_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        put_event(OP_UNKNOWN_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
        put_event(OP_ENABLE, '0, '0, '0, 1'b1, 1'b0);
        put_event(OP_ENABLE, '0, '0, '0, 1'b1, 1'b0);
        put_event(OP_ENABLE, '0, '0, '0, 1'b1, 1'b1);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    lim        = '{15'd0, 15'd0, 15'd0};
                    cmd_ticks  = 16'd1;
                    state_ticks = 16'd1;
                    need_state = 1'b1;
                end
                1: begin
                    lim        = '{15'h7FFF, 15'h7FFF, 15'h7FFF};
                    cmd_ticks  = 16'hFFFF;
                    state_ticks = 16'hFFFF;
                    need_state = 1'b0;
                end
                2: begin
                    lim        = '{15'h7FFF, 15'h7FFF, 15'h7FFF};
                    cmd_ticks  = 16'd1;
                    state_ticks = 16'hFFFF;
                    need_state = 1'b1;
                end
                3: begin
                    lim        = '{15'd0, 15'd0, 15'd0};
                    cmd_ticks  = 16'hFFFF;
                    state_ticks = 16'd1;
                    need_state = 1'b0;
                end
                default: begin
                    for (int i = 0; i < 3; i++)
                        lim[i] = $urandom_range(0, 1) ? 15'($urandom_range(0, 600))
                                                      : 15'($urandom_range(0, 32767));
                    cmd_ticks   = 16'($urandom_range(1, 40));
                    state_ticks = 16'($urandom_range(1, 60));
                    need_state  = 1'($urandom_range(0, 1));
                end
            endcase
            settle();
            apply_config({1'($urandom_range(0, 1)), lim[0]}, {1'($urandom_range(0, 1)), lim[1]},
                         {1'($urandom_range(0, 1)), lim[2]}, cmd_ticks, state_ticks,
                         {15'($urandom), need_state}, {15'($urandom), 1'($urandom_range(0, 1))});
            run_random(PHASE_EVENTS, 1'b1);
        end

        // The receiver holds off while enable requests keep coming, so the block fills up.
        settle();
        apply_config(16'd1000, 16'd500, 16'd2000, 16'd30, 16'd60, 16'd1, 16'd0);
        put_event(OP_STATE, '0, '0, '0, 1'b1, 1'b0);
        sink_hold_req = 1'b1;
        for (int n = 0; n < 30; n++)
            put_event(OP_ENABLE, random_velocity(cur_limit_fwd), '0, '0, 1'b1, n[0]);
        settle();
        put_event(OP_ENABLE, '0, '0, '0, 1'b1, 1'b1);
        put_event(OP_VELOCITY, 16'd700, 16'hFE00, 16'd3000, 1'b1, 1'b0);
        put_event(OP_TICK, '0, '0, '0, 1'b1, 1'b0);

        sink_quiet = 1'b1;
        run_random(CLOSING_EVENTS, 1'b0);
        settle();

        if (fail_count == 0 && outstanding == 0) begin
            $display("motion_command_watchdog_gate_core test passed");
        end else begin
            $display("motion_command_watchdog_gate_core test failed");
        end
        $finish;
    end

endmodule

// File: motion_command_watchdog_gate_core.f
rtl/core/mcwg_pkg.sv
rtl/core/mcwg_clamp.sv
rtl/core/motion_command_watchdog_gate_core.sv
verif/mcwg_checker.sv
verif/tb_top.sv
